/* sv/gida_pkg.sv */
// ---------------------------------------------------------------------------
// gida_pkg
// Shared types, codes and the degree classifier of the degree group id
// allocator.
// ---------------------------------------------------------------------------
package gida_pkg;

    localparam int NUM_CLASSES = 8;
    localparam int CLASS_W     = 3;
    localparam int ID_W        = 32;
    localparam int HIST_W      = 17;
    localparam int AVG_W       = 24;
    localparam int SLOTS_W     = 16;
    localparam int VID_W       = 16;
    localparam int DEG_W       = 16;
    localparam int REQ_W       = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 24;

    localparam logic [CLASS_W-1:0] CLASS_LAST = CLASS_W'(NUM_CLASSES - 1);
    localparam logic [HIST_W-1:0]  HIST_MAX   = {HIST_W{1'b1}};

    // request kinds
    localparam logic [REQ_W-1:0] REQ_TALLY  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_LAYOUT = 2'd1;
    localparam logic [REQ_W-1:0] REQ_MAP    = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_AVG_DEGREE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOTS      = 2'd1;

    typedef struct packed {
        logic             valid;
        logic [ID_W-1:0]  id;
    } id_entry_t;

    typedef struct packed {
        logic               tally;
        logic               alloc;
        logic               layout_start;
        logic [CLASS_W-1:0] grp;
    } class_cmd_t;

    typedef struct packed {
        logic            layout_busy;
        logic [ID_W-1:0] next_id;
        logic [ID_W-1:0] end_id;
    } class_sts_t;

    // degree vs multiples of the average, both in q9; ties drop one class
    function automatic logic [CLASS_W-1:0] classify(input logic [DEG_W-1:0] deg,
                                                    input logic [AVG_W-1:0] avg);
        logic [30:0]        d9;
        logic [30:0]        a9;
        logic [CLASS_W-1:0] cls;
        d9  = {6'd0, deg, 9'd0};
        a9  = {6'd0, avg, 1'b0};
        cls = CLASS_LAST;
        if (d9 > {7'd0, avg}) begin
            cls = CLASS_W'(NUM_CLASSES - 2);
        end
        for (int k = 5; k >= 0; k--) begin
            if (d9 > (a9 << (5 - k))) begin
                cls = CLASS_W'(k);
            end
        end
        return cls;
    endfunction

endpackage

/* sv/degree_group_id_allocator_unit.sv */
// ---------------------------------------------------------------------------
// degree_group_id_allocator_unit
// Sorts vertex degrees into classes, lays out per-class id ranges and hands
// out new vertex ids from a table held in one synchronous memory.
// ---------------------------------------------------------------------------
//  channel   | dir | handshake         | payload
//  ----------+-----+-------------------+------------------------------------
//  s_ (req)  | in  | s_tvalid/s_tready | s_tdata, s_tuser
//  m_ (res)  | out | m_tvalid/m_tready | m_tdata
//  cfg_      | in  | cfg_valid/ready   | cfg_index, cfg_data
//
//  one request at a time: a tally goes straight to emit, a map reads the table,
//  then writes back, and a layout walks one class per cycle through the
//  multiplier, then sees the walk finish and emits
//  after reset all 2**VERTEX_BITS table entries are swept clear with
//  s_tready low
//  a request is taken while the previous result still waits on m_; the
//  engine holds its finished result until the output register frees up
// ---------------------------------------------------------------------------
module degree_group_id_allocator_unit #(
    parameter int VERTEX_BITS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [31:0]                         s_tdata,   // vertex_id, degree
    input  logic [gida_pkg::REQ_W-1:0]          s_tuser,   // req_type
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [39:0]                         m_tdata,   // new_id, group_index,
                                                           // already_mapped, group_full
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [gida_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [gida_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import gida_pkg::*;

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_LAYOUT = 3'd2;
    localparam logic [2:0] ST_LOOKUP = 3'd3;
    localparam logic [2:0] ST_EMIT   = 3'd4;

    logic [2:0]             state_reg;
    logic [2:0]             state_next;
    logic [VERTEX_BITS-1:0] clr_cnt_reg;
    logic [AVG_W-1:0]       avg_reg;
    logic [SLOTS_W-1:0]     slots_reg;
    logic [VERTEX_BITS-1:0] slot_reg;
    logic [CLASS_W-1:0]     grp_reg;

    logic [ID_W-1:0]        pend_id_reg;
    logic [CLASS_W-1:0]     pend_grp_reg;
    logic                   pend_map_reg;
    logic                   pend_full_reg;

    logic                   m_valid_reg;
    logic [ID_W-1:0]        m_id_reg;
    logic [CLASS_W-1:0]     m_grp_reg;
    logic                   m_map_reg;
    logic                   m_full_reg;

    logic [VID_W-1:0]       in_vid;
    logic [DEG_W-1:0]       in_deg;
    logic [VERTEX_BITS-1:0] in_slot;
    logic [CLASS_W-1:0]     in_grp;
    logic                   accept;
    logic                   out_free;
    logic                   lookup_hit;
    logic [ID_W-1:0]        alloc_next;

    class_cmd_t             cmd;
    class_sts_t             sts;

    logic                   ram_wr_en;
    logic [VERTEX_BITS-1:0] ram_wr_addr;
    id_entry_t              ram_wr_data;
    id_entry_t              ram_rd_data;

    assign in_vid   = s_tdata[VID_W-1:0];
    assign in_deg   = s_tdata[VID_W+DEG_W-1:VID_W];
    assign in_slot  = VERTEX_BITS'({{VERTEX_BITS{1'b0}}, in_vid});
    assign in_grp   = classify(in_deg, avg_reg);
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    assign lookup_hit = ram_rd_data.valid;
    assign alloc_next = sts.next_id + 1'b1;

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            avg_reg   <= AVG_W'(256);
            slots_reg <= SLOTS_W'(1);
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_AVG_DEGREE: avg_reg   <= cfg_data;
                CFG_SLOTS:      slots_reg <= cfg_data[SLOTS_W-1:0];
                default: ;
            endcase
        end
    end

    // class file commands
    always_comb begin
        cmd.tally        = accept && (s_tuser == REQ_TALLY);
        cmd.layout_start = accept && (s_tuser == REQ_LAYOUT);
        cmd.alloc        = (state_reg == ST_LOOKUP) && !lookup_hit;
        cmd.grp          = (state_reg == ST_IDLE) ? in_grp : grp_reg;
    end

    gida_class_file u_class_file (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .slots_per_count (slots_reg),
        .sts             (sts)
    );

    // table write: clearing sweep or allocation write back
    always_comb begin
        ram_wr_en         = 1'b0;
        ram_wr_addr       = slot_reg;
        ram_wr_data.valid = 1'b1;
        ram_wr_data.id    = sts.next_id;
        if (state_reg == ST_CLEAR) begin
            ram_wr_en         = 1'b1;
            ram_wr_addr       = clr_cnt_reg;
            ram_wr_data.valid = 1'b0;
            ram_wr_data.id    = '0;
        end else if (cmd.alloc) begin
            ram_wr_en = 1'b1;
        end
    end

    gida_id_ram #(
        .ADDR_W (VERTEX_BITS)
    ) u_id_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (accept),
        .rd_addr (in_slot),
        .rd_data (ram_rd_data)
    );

    // sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (clr_cnt_reg == {VERTEX_BITS{1'b1}}) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    case (s_tuser)
                        REQ_LAYOUT: state_next = ST_LAYOUT;
                        REQ_MAP:    state_next = ST_LOOKUP;
                        default:    state_next = ST_EMIT;
                    endcase
                end
            end
            ST_LAYOUT: begin
                if (!sts.layout_busy) begin
                    state_next = ST_EMIT;
                end
            end
            ST_LOOKUP: state_next = ST_EMIT;
            ST_EMIT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
        end
    end

    // request fields and pending result
    always_ff @(posedge aclk) begin
        if (accept) begin
            slot_reg      <= in_slot;
            grp_reg       <= in_grp;
            pend_id_reg   <= '0;
            pend_map_reg  <= 1'b0;
            pend_full_reg <= 1'b0;
            if (s_tuser == REQ_TALLY || s_tuser == REQ_MAP) begin
                pend_grp_reg <= in_grp;
            end else begin
                pend_grp_reg <= '0;
            end
        end else if (state_reg == ST_LOOKUP) begin
            if (lookup_hit) begin
                pend_id_reg  <= ram_rd_data.id;
                pend_map_reg <= 1'b1;
            end else begin
                pend_id_reg   <= sts.next_id;
                pend_full_reg <= (alloc_next == sts.end_id);
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == ST_EMIT && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_EMIT && out_free) begin
            m_id_reg   <= pend_id_reg;
            m_grp_reg  <= pend_grp_reg;
            m_map_reg  <= pend_map_reg;
            m_full_reg <= pend_full_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, m_full_reg, m_map_reg, m_grp_reg, m_id_reg};

endmodule

/* sv/gida_id_ram.sv */
// ---------------------------------------------------------------------------
// gida_id_ram
// Vertex id table: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module gida_id_ram #(
    parameter int ADDR_W = 16
) (
    input  logic                  aclk,
    input  logic                  wr_en,
    input  logic [ADDR_W-1:0]     wr_addr,
    input  gida_pkg::id_entry_t   wr_data,
    input  logic                  rd_en,
    input  logic [ADDR_W-1:0]     rd_addr,
    output gida_pkg::id_entry_t   rd_data
);
    import gida_pkg::*;

    localparam int DEPTH = 1 << ADDR_W;

    id_entry_t ram_reg [DEPTH];
    id_entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            ram_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= ram_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* sv/gida_class_file.sv */
// ---------------------------------------------------------------------------
// gida_class_file
// Per-class histogram, allocation pointer and range end, with the range
// layout sequencer that walks the classes one per cycle.
// ---------------------------------------------------------------------------
module gida_class_file (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  gida_pkg::class_cmd_t                cmd,
    input  logic [gida_pkg::SLOTS_W-1:0]        slots_per_count,
    output gida_pkg::class_sts_t                sts
);
    import gida_pkg::*;

    logic [HIST_W-1:0]  hist_reg [NUM_CLASSES];
    logic [ID_W-1:0]    next_reg [NUM_CLASSES];
    logic [ID_W-1:0]    end_reg  [NUM_CLASSES];
    logic               busy_reg;
    logic [CLASS_W-1:0] idx_reg;
    logic [ID_W-1:0]    start_reg;

    logic [CLASS_W-1:0] cls_addr;
    logic [HIST_W-1:0]  hist_rd;
    logic [ID_W:0]      prod;
    logic [ID_W-1:0]    width;
    logic [ID_W-1:0]    end_next;

    // one read address: the layout walk or the requested class
    assign cls_addr = busy_reg ? idx_reg : cmd.grp;
    assign hist_rd  = hist_reg[cls_addr];
    assign prod     = (ID_W+1)'(hist_rd) * (ID_W+1)'(slots_per_count);
    assign width    = prod[ID_W-1:0];
    assign end_next = start_reg + width;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_CLASSES; i++) begin
                hist_reg[i] <= '0;
                next_reg[i] <= '0;
                end_reg[i]  <= '0;
            end
            busy_reg  <= 1'b0;
            idx_reg   <= '0;
            start_reg <= '0;
        end else if (cmd.layout_start) begin
            busy_reg  <= 1'b1;
            idx_reg   <= '0;
            start_reg <= '0;
        end else if (busy_reg) begin
            next_reg[idx_reg] <= start_reg;
            hist_reg[idx_reg] <= '0;
            if (idx_reg != CLASS_LAST) begin
                end_reg[idx_reg] <= end_next;
                start_reg        <= end_next + 1'b1;
            end else begin
                end_reg[idx_reg] <= '0;
                busy_reg         <= 1'b0;
            end
            idx_reg <= CLASS_W'(idx_reg + 1'b1);
        end else begin
            if (cmd.tally && hist_rd != HIST_MAX) begin
                hist_reg[cls_addr] <= hist_rd + 1'b1;
            end
            if (cmd.alloc) begin
                next_reg[cls_addr] <= next_reg[cls_addr] + 1'b1;
            end
        end
    end

    assign sts.layout_busy = busy_reg;
    assign sts.next_id     = next_reg[cls_addr];
    assign sts.end_id      = end_reg[cls_addr];

endmodule

/* verif/degree_group_id_allocator_unit_test.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// degree_group_id_allocator_unit_test
// Self-checking bench for the degree class id allocator. A shadow of the
// class counts, range pointers and vertex id table predicts every result
// beat; a checker process compares each beat against the oldest prediction.
// Directed boundary cases come first, then wide class ranges at the largest
// slot count, then randomized tally/layout/map rounds under random idles and
// output stalls.
// ---------------------------------------------------------------------------
module degree_group_id_allocator_unit_test;
    import gida_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 4_000_000;
    localparam int          TABLE_DEPTH = 1 << VID_W;
    localparam int          MAP_HISTORY = 64;
    localparam int          RANDOM_ITEMS = 840;

    localparam logic [REQ_W-1:0]     REQ_NONE   = 2'd3;   // unused request kind
    localparam logic [CFG_IDX_W-1:0] CFG_RSVD_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RSVD_3 = 2'd3;

    typedef struct packed {
        logic [ID_W-1:0]    new_id;
        logic [CLASS_W-1:0] grp;
        logic               mapped;
        logic               full;
    } alloc_result_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic [31:0]           s_tdata   = '0;
    logic [REQ_W-1:0]      s_tuser   = '0;
    logic                  m_tready  = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_tready;
    logic                  m_tvalid;
    logic [39:0]           m_tdata;
    logic                  cfg_ready;

    degree_group_id_allocator_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // shadow of the allocator state
    logic [AVG_W-1:0]   avg_q8;
    logic [SLOTS_W-1:0] slots;
    logic [HIST_W-1:0]  class_count [NUM_CLASSES];
    logic [ID_W-1:0]    class_next  [NUM_CLASSES];
    logic [ID_W-1:0]    class_end   [NUM_CLASSES];
    logic [ID_W-1:0]    vid_to_id   [TABLE_DEPTH];
    bit                 vid_known   [TABLE_DEPTH];

    alloc_result_t      pending_results [$];
    logic [VID_W-1:0]   mapped_vids [$];

    int unsigned cycle_count     = 0;
    int unsigned accepted_items  = 0;
    int unsigned checked_results = 0;
    int unsigned mismatches      = 0;
    int unsigned full_seen       = 0;
    int unsigned remap_seen      = 0;
    int unsigned stall_left      = 0;
    bit          gaps_on         = 1'b1;
    bit          stalls_on       = 1'b1;

    initial begin
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("run stopped at cycle limit, %0d results still pending",
                     pending_results.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // mostly short idles, now and then a long one
    function automatic int unsigned pick_idle();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // class by comparing degree and average, both in q9
    function automatic logic [CLASS_W-1:0] degree_class(input logic [DEG_W-1:0] deg);
        longint unsigned deg_q9;
        longint unsigned avg_q9;
        deg_q9 = 64'(deg) << 9;
        avg_q9 = 64'(avg_q8) << 1;
        for (int c = 0; c < NUM_CLASSES - 2; c++) begin
            if (deg_q9 > (avg_q9 << (5 - c))) return CLASS_W'(c);
        end
        if (deg_q9 > 64'(avg_q8)) return CLASS_W'(NUM_CLASSES - 2);
        return CLASS_LAST;
    endfunction

    function automatic alloc_result_t predict_request(input logic [REQ_W-1:0] req,
                                                      input logic [VID_W-1:0] vid,
                                                      input logic [DEG_W-1:0] deg);
        alloc_result_t      res;
        logic [CLASS_W-1:0] g;
        logic [ID_W-1:0]    start;
        logic [ID_W-1:0]    width;
        res = '0;
        case (req)
            REQ_TALLY: begin
                g = degree_class(deg);
                res.grp = g;
                if (class_count[g] != HIST_MAX) class_count[g] = class_count[g] + 1'b1;
            end
            REQ_LAYOUT: begin
                start = '0;
                for (int c = 0; c < NUM_CLASSES; c++) begin
                    class_next[c] = start;
                    if (c != NUM_CLASSES - 1) begin
                        width        = ID_W'(class_count[c]) * ID_W'(slots);
                        class_end[c] = start + width;
                        start        = start + width + 1;
                    end else begin
                        class_end[c] = '0;
                    end
                    class_count[c] = '0;
                end
            end
            REQ_MAP: begin
                g = degree_class(deg);
                res.grp = g;
                if (vid_known[vid]) begin
                    res.new_id = vid_to_id[vid];
                    res.mapped = 1'b1;
                end else begin
                    res.new_id    = class_next[g];
                    class_next[g] = class_next[g] + 1;
                    res.full      = (class_next[g] == class_end[g]);
                    vid_to_id[vid] = res.new_id;
                    vid_known[vid] = 1'b1;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic send_req(input logic [REQ_W-1:0] req, input logic [VID_W-1:0] vid,
                            input logic [DEG_W-1:0] deg);
        int unsigned gap;
        gap = gaps_on ? pick_idle() : 0;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {deg, vid};
        do @(posedge aclk); while (!s_tready);
        pending_results = {pending_results, predict_request(req, vid, deg)};
        if (req != REQ_NONE) accepted_items++;
        if (req == REQ_MAP) begin
            mapped_vids = {mapped_vids, vid};
            if (mapped_vids.size() > MAP_HISTORY) void'(mapped_vids.pop_front());
        end
    endtask

    // registers change only with the engine idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_AVG_DEGREE: avg_q8 = data;
            CFG_SLOTS:      slots  = data[SLOTS_W-1:0];
            default: ;
        endcase
    endtask

    function automatic logic [VID_W-1:0] fresh_vertex();
        logic [VID_W-1:0] v;
        do v = VID_W'($urandom); while (vid_known[v]);
        return v;
    endfunction

    function automatic logic [VID_W-1:0] pick_vertex();
        if (mapped_vids.size() != 0 && $urandom_range(0, 99) < 25)
            return mapped_vids[$urandom_range(0, mapped_vids.size() - 1)];
        return VID_W'($urandom);
    endfunction

    // log-spread degrees, with exact threshold ties mixed in
    function automatic logic [DEG_W-1:0] pick_degree();
        int unsigned     r;
        longint unsigned tie;
        r = $urandom_range(0, 99);
        if (r < 12) begin
            tie = (64'(avg_q8) << $urandom_range(0, 6)) >> 9;
            return (tie > 65535) ? '1 : DEG_W'(tie);
        end
        if (r < 20) return r[0] ? '1 : '0;
        return DEG_W'($urandom_range(0, 65535) >> $urandom_range(0, 16));
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_average();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 12) return '0;
        if (r < 22) return '1;
        if (r < 55) return CFG_DATA_W'($urandom);
        return CFG_DATA_W'($urandom_range(16, 8192));
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_slots();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 12) return CFG_DATA_W'(1);
        if (r < 22) return CFG_DATA_W'(65535);
        if (r < 72) return CFG_DATA_W'($urandom_range(1, 4));
        return CFG_DATA_W'($urandom_range(1, 65535));
    endfunction

    // output back-pressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (stall_left != 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_tready <= 1'b1;
            if (stalls_on && $urandom_range(0, 99) < 20) stall_left <= pick_idle();
        end
    end

    // result checker
    always @(posedge aclk) begin
        alloc_result_t got;
        alloc_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.new_id = m_tdata[ID_W-1:0];
            got.grp    = m_tdata[ID_W+CLASS_W-1:ID_W];
            got.mapped = m_tdata[ID_W+CLASS_W];
            got.full   = m_tdata[ID_W+CLASS_W+1];
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result beat with no request pending: %h", m_tdata);
            end else begin
                want = pending_results.pop_front();
                checked_results++;
                if (want.full) full_seen++;
                if (want.mapped) remap_seen++;
                if (got.new_id !== want.new_id || got.grp !== want.grp ||
                    got.mapped !== want.mapped || got.full !== want.full) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("result %0d: expected id %h class %0d mapped %0b full %0b",
                                 checked_results, want.new_id, want.grp, want.mapped,
                                 want.full);
                        $display("result %0d: got      id %h class %0d mapped %0b full %0b",
                                 checked_results, got.new_id, got.grp, got.mapped,
                                 got.full);
                    end
                end
            end
        end
    end

    // defaults: average 1.0, one slot per count
    task automatic test_class_boundaries();
        logic [DEG_W-1:0] tally_degrees [9];
        tally_degrees = '{16'hFFFF, 16'd33, 16'd32, 16'd16, 16'd8, 16'd4, 16'd2, 16'd1, 16'd0};
        foreach (tally_degrees[i]) send_req(REQ_TALLY, VID_W'(i), tally_degrees[i]);
        send_req(REQ_NONE, 16'hFFFF, 16'hFFFF);
        send_req(REQ_LAYOUT, 16'h0000, 16'h0000);
        send_req(REQ_MAP, 16'h0000, 16'd40);
        send_req(REQ_MAP, 16'hFFFF, 16'd33);    // second of two class 0 slots
        send_req(REQ_MAP, 16'h5555, 16'd1);
        send_req(REQ_MAP, 16'hAAAA, 16'd0);
        send_req(REQ_MAP, 16'h0000, 16'd3);     // stored id, class of the new degree
    endtask

    task automatic test_average_extremes();
        write_reg(CFG_AVG_DEGREE, '0);
        send_req(REQ_MAP, fresh_vertex(), 16'd0);
        send_req(REQ_MAP, fresh_vertex(), 16'd1);
        send_req(REQ_TALLY, 16'h1234, 16'hFFFF);
        write_reg(CFG_AVG_DEGREE, 24'd512);
        send_req(REQ_TALLY, 16'h0001, 16'd1);   // tie on the half threshold
        send_req(REQ_TALLY, 16'h0002, 16'd2);
        write_reg(CFG_AVG_DEGREE, '1);
        write_reg(CFG_SLOTS, 24'd3);
        write_reg(CFG_RSVD_2, 24'hA5A5A5);
        write_reg(CFG_RSVD_3, 24'h5A5A5A);
        send_req(REQ_LAYOUT, 16'h0000, 16'h0000);
        send_req(REQ_MAP, fresh_vertex(), 16'hFFFF);
        send_req(REQ_MAP, fresh_vertex(), 16'h0000);
    endtask

    // largest slot count: class ranges hundreds of thousands of ids wide, full products
    task automatic test_wide_ranges();
        write_reg(CFG_AVG_DEGREE, 24'd256);
        write_reg(CFG_SLOTS, 24'd65535);
        repeat (12)
            send_req(REQ_TALLY, VID_W'($urandom), DEG_W'($urandom_range(33, 65535)));
        repeat (9)
            send_req(REQ_TALLY, VID_W'($urandom), DEG_W'($urandom_range(17, 32)));
        send_req(REQ_LAYOUT, 16'h0000, 16'h0000);
        send_req(REQ_MAP, fresh_vertex(), 16'd40);
        send_req(REQ_MAP, fresh_vertex(), 16'd20);
        send_req(REQ_MAP, fresh_vertex(), 16'd10);
        send_req(REQ_MAP, fresh_vertex(), 16'd12);
        send_req(REQ_MAP, fresh_vertex(), 16'd0);
    endtask

    task automatic test_random_traffic();
        int unsigned target;
        int unsigned n;
        int unsigned r;
        target = accepted_items + RANDOM_ITEMS;
        while (accepted_items < target) begin
            gaps_on   = ($urandom_range(0, 3) != 0);
            stalls_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 2) == 0) begin
                write_reg(CFG_AVG_DEGREE, pick_average());
                if ($urandom_range(0, 1) == 0) write_reg(CFG_SLOTS, pick_slots());
            end
            n = $urandom_range(0, 20);
            repeat (n) begin
                if ($urandom_range(0, 99) < 4)
                    send_req(REQ_NONE, VID_W'($urandom), DEG_W'($urandom));
                else
                    send_req(REQ_TALLY, VID_W'($urandom), pick_degree());
            end
            if ($urandom_range(0, 9) != 0)
                send_req(REQ_LAYOUT, VID_W'($urandom), DEG_W'($urandom));
            n = $urandom_range(5, 40);
            repeat (n) begin
                r = $urandom_range(0, 99);
                if (r < 4)
                    send_req(REQ_TALLY, VID_W'($urandom), pick_degree());
                else if (r < 7)
                    send_req(REQ_NONE, VID_W'($urandom), DEG_W'($urandom));
                else if (r < 9)
                    send_req(REQ_LAYOUT, VID_W'($urandom), DEG_W'($urandom));
                else
                    send_req(REQ_MAP, pick_vertex(), pick_degree());
            end
        end
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
    endtask

    initial begin
        avg_q8 = 24'd256;
        slots  = 16'd1;
        for (int c = 0; c < NUM_CLASSES; c++) begin
            class_count[c] = '0;
            class_next[c]  = '0;
            class_end[c]   = '0;
        end
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        test_class_boundaries();
        test_average_extremes();
        test_wide_ranges();
        test_random_traffic();

        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("%0d requests accepted, %0d results checked in %0d cycles",
                 accepted_items, checked_results, cycle_count);
        $display("%0d class ranges filled, %0d lookups of already numbered vertices",
                 full_seen, remap_seen);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
